@@ rtl/unordered_max_priority_queue_assert.svh @@
// Assertion macros for the RTL of the priority queue.
`ifndef UNORDERED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define UNORDERED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UPQ_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UPQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/upq_pkg.sv @@
package upq_pkg;

   localparam int QUEUE_DEPTH_DEF  = 64;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int KEY_W    = 32;
   localparam int PAY_IN_W = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = KEY_W + PAY_IN_W;
   localparam int RSP_FIELD_W = KEY_W + PAY_IN_W + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_EXTRACTED = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Control of the max-search unit for one read beat.
   typedef struct packed {
      logic vld;
      logic first;
   } scan_ctl_type;

endpackage

@@ rtl/upq_store.sv @@
module upq_store #(
   parameter int DEPTH  = upq_pkg::QUEUE_DEPTH_DEF,
   parameter int DATA_W = upq_pkg::KEY_W + upq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   import upq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/upq_scan.sv @@
module upq_scan #(
   parameter int ADDR_W  = 6,
   parameter int STORE_W = upq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                      clock,
   input  upq_pkg::scan_ctl_type     ctl,
   input  logic [ADDR_W-1:0]         idx,
   input  logic [upq_pkg::KEY_W-1:0] key,
   input  logic [STORE_W-1:0]        payload,
   output logic [ADDR_W-1:0]         best_idx,
   output logic [upq_pkg::KEY_W-1:0] best_key,
   output logic [STORE_W-1:0]        best_payload
);
   import upq_pkg::*;

   logic [ADDR_W-1:0]  best_idx_ff;
   logic [KEY_W-1:0]   best_key_ff;
   logic [STORE_W-1:0] best_pay_ff;
   logic               take;

   // Strict greater-than: on equal keys the older entry stays.
   assign take = ctl.vld && (ctl.first || ($signed(key) > $signed(best_key_ff)));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= idx;
         best_key_ff <= key;
         best_pay_ff <= payload;
      end
   end

   assign best_idx     = best_idx_ff;
   assign best_key     = best_key_ff;
   assign best_payload = best_pay_ff;

endmodule

@@ rtl/unordered_max_priority_queue.sv @@
// Insert: the accepted transaction loads the result register directly.
// Extract on n stored entries: one store read per cycle serves
// both the max scan (n reads) and the compaction behind the winner.
// The block takes no new transaction while an extract is in progress.
// Reset clears the occupancy, the sequencer and the result valid flag;
// store contents and the result data fields are not cleared.
module unordered_max_priority_queue #(
   parameter int QUEUE_DEPTH  = upq_pkg::QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = upq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] key, [63:32] payload
   input  logic [upq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] max_key, [63:32] max_payload, [70:64] entry_count, [71] zero
   output logic [upq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [upq_pkg::STATUS_W-1:0]    rsp_tuser
);
   import upq_pkg::*;
   `include "unordered_max_priority_queue_assert.svh"

   localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_W = (PAYLOAD_BITS < PAY_IN_W) ? PAYLOAD_BITS : PAY_IN_W;
   localparam int MEM_W   = KEY_W + STORE_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_PREP = 4'b0100,
      ST_MOVE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               dv_ff;
   logic [CNT_W-1:0]   dv_idx_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [PAY_IN_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_load;

   logic               accept, out_free, is_full, is_empty;
   logic               rd_en, wr_en, issue, move_done;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [MEM_W-1:0]   wr_data, rd_data;
   logic [CNT_W-1:0]   prev_idx;

   scan_ctl_type       scan_ctl;
   logic [ADDR_W-1:0]  best_idx;
   logic [KEY_W-1:0]   best_key;
   logic [STORE_W-1:0] best_pay;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty   = (occ_ff == '0);
   assign issue      = (rd_idx_ff < occ_ff);
   assign move_done  = !issue && !dv_ff;
   assign prev_idx   = dv_idx_ff - 1'b1;

   assign scan_ctl.vld   = dv_ff && (state_ff == ST_SCAN);
   assign scan_ctl.first = (dv_idx_ff == '0);

   upq_store #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (MEM_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   upq_scan #(
      .ADDR_W  (ADDR_W),
      .STORE_W (STORE_W)
   ) u_scan (
      .clock        (clock),
      .ctl          (scan_ctl),
      .idx          (dv_idx_ff[ADDR_W-1:0]),
      .key          (rd_data[KEY_W-1:0]),
      .payload      (rd_data[MEM_W-1:KEY_W]),
      .best_idx     (best_idx),
      .best_key     (best_key),
      .best_payload (best_pay)
   );

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      rd_idx_in     = rd_idx_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = prev_idx[ADDR_W-1:0];
      wr_data       = rd_data;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_INSERTED;
      rsp_key_in    = '0;
      rsp_pay_in    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               if (req_tuser[0] == OP_INSERT) begin
                  if (is_full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = occ_ff[ADDR_W-1:0];
                     wr_data       = {req_tdata[KEY_W +: STORE_W], req_tdata[KEY_W-1:0]};
                     occ_in        = occ_ff + 1'b1;
                     rsp_status_in = STATUS_INSERTED;
                  end
               end else if (is_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  // Start the scan with entry zero; result comes at the end.
                  rsp_load  = 1'b0;
                  rd_en     = 1'b1;
                  rd_addr   = '0;
                  rd_idx_in = CNT_W'(1);
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (dv_ff && (dv_idx_ff == occ_ff - 1'b1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rd_idx_in = CNT_W'(best_idx) + 1'b1;
            state_in  = ST_MOVE;
         end
         ST_MOVE: begin
            // Shift every entry behind the winner down by one address.
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (dv_ff) begin
               wr_en = 1'b1;
            end
            if (move_done && out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_EXTRACTED;
               rsp_key_in    = best_key;
               rsp_pay_in    = PAY_IN_W'(best_pay);
               occ_in        = occ_ff - 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_cnt_in   = COUNT_W'(occ_in);
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rd_idx_ff    <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_idx_ff    <= rd_idx_in;
         dv_ff        <= rd_en && (state_ff != ST_IDLE || accept);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         dv_idx_ff <= (state_ff == ST_IDLE) ? '0 : rd_idx_ff;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_cnt_ff    <= rsp_cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_cnt_ff, rsp_pay_ff, rsp_key_ff};

   `UPQ_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1,
      occ_ff <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
   `UPQ_ASSERT_IMPL(a_no_write_in_scan, clock, reset,
      (state_ff == ST_SCAN) || (state_ff == ST_PREP), !wr_en, "store written during scan")
   `UPQ_ASSERT_IMPL(a_read_in_range, clock, reset,
      rd_en && (state_ff != ST_IDLE), rd_idx_ff < occ_ff, "read beyond occupancy")
   `UPQ_ASSERT_NEXT(a_extract_result, clock, reset,
      (state_ff == ST_MOVE) && move_done && out_free,
      rsp_tvalid && (rsp_status_ff == STATUS_EXTRACTED) && (occ_ff == $past(occ_ff) - 1'b1),
      "extract did not complete")

endmodule
